### design/wsma_pkg.sv
`default_nettype none

package wsma_pkg;

    // Sizes of the sample path and of the window store.
    localparam int SAMPLE_BITS = 32;
    localparam int WINDOW_MAX  = 64;
    localparam int ADDR_BITS   = $clog2(WINDOW_MAX);
    localparam int WIN_BITS    = ADDR_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + ADDR_BITS;

    // Q1.16 smoothing factor and the products of the EMA step.
    localparam int FRAC_BITS   = 16;
    localparam int FACTOR_BITS = FRAC_BITS + 1;
    localparam int PROD_BITS   = SAMPLE_BITS + FACTOR_BITS;

    // Configuration port data width: the widest register.
    localparam int CFG_DATA_BITS = FACTOR_BITS;

    // Restoring divider: one quotient bit per step over the whole sum.
    localparam int DIV_STEPS      = SUM_BITS;
    localparam int DIV_COUNT_BITS = $clog2(DIV_STEPS);

    localparam logic [FACTOR_BITS-1:0] ONE_Q16    = FACTOR_BITS'(1) << FRAC_BITS;
    localparam logic [PROD_BITS-1:0]   ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

    localparam logic [WIN_BITS-1:0]    WINDOW_LENGTH_RESET = WIN_BITS'(20);
    localparam logic [FACTOR_BITS-1:0] SMOOTHING_RESET     = FACTOR_BITS'(6554);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_WINDOW_LENGTH    = 1'b0,
        REG_SMOOTHING_FACTOR = 1'b1
    } cfg_index_t;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_OLD      = 8'b0000_0010,
        S_UPDATE   = 8'b0000_0100,
        S_LOAD     = 8'b0000_1000,
        S_INIT     = 8'b0001_0000,
        S_MUL_NEW  = 8'b0010_0000,
        S_MUL_OLD  = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    // A written length of zero acts as one; anything above the store depth
    // acts as the store depth.
    function automatic logic [WIN_BITS-1:0] effective_window(input logic [WIN_BITS-1:0] len);
        logic [WIN_BITS-1:0] win;
        win = len;
        if (len == '0)
        begin
            win = WIN_BITS'(1);
        end
        else if (len > WIN_BITS'(WINDOW_MAX))
        begin
            win = WIN_BITS'(WINDOW_MAX);
        end
        return win;
    endfunction

endpackage

`default_nettype wire

### design/wsma_if.sv
`default_nettype none

// Sample channel: one Q16.16 sample per beat.
interface wsma_in_if;
    logic                             valid;
    logic                             ready;
    logic [wsma_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Result channel: both averages travel in one beat.
interface wsma_out_if;
    logic                             valid;
    logic                             ready;
    logic [wsma_pkg::SAMPLE_BITS-1:0] simple_average;
    logic [wsma_pkg::SAMPLE_BITS-1:0] exponential_average;

    modport source (output valid, output simple_average, output exponential_average,
                    input ready);
    modport sink   (input valid, input simple_average, input exponential_average,
                    output ready);
endinterface

// Configuration write channel: register index and data per beat.
interface wsma_cfg_if;
    logic                               valid;
    logic                               ready;
    wsma_pkg::cfg_index_t               index;
    logic [wsma_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/wsma_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module wsma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/wsma_div.sv
`default_nettype none

// Restoring divider for the simple average: one quotient bit per cycle.
// The quotient of the window sum by the fill count always fits a sample.
module wsma_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [wsma_pkg::SUM_BITS-1:0]    dividend,
    input  wire logic [wsma_pkg::WIN_BITS-1:0]    divisor,
    output logic                                  done,
    output logic      [wsma_pkg::SAMPLE_BITS-1:0] quotient
);

    logic                                  busy_reg;
    logic                                  done_reg;
    logic [wsma_pkg::DIV_COUNT_BITS-1:0]   count_reg;
    logic [wsma_pkg::SUM_BITS-1:0]         work_reg;
    logic [wsma_pkg::WIN_BITS-1:0]         rem_reg;
    logic [wsma_pkg::WIN_BITS-1:0]         divisor_reg;

    logic [wsma_pkg::WIN_BITS:0]           trial;
    logic                                  fits;
    logic [wsma_pkg::WIN_BITS-1:0]         rem_next;
    logic [wsma_pkg::SUM_BITS-1:0]         work_next;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial     = {rem_reg, work_reg[wsma_pkg::SUM_BITS-1]};
        fits      = (trial >= {1'b0, divisor_reg});
        rem_next  = fits ? wsma_pkg::WIN_BITS'(trial - {1'b0, divisor_reg})
                         : wsma_pkg::WIN_BITS'(trial);
        work_next = {work_reg[wsma_pkg::SUM_BITS-2:0], fits};
    end

    // Control: busy while stepping, done held until the next start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && (count_reg == '0))
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    // Datapath: the dividend register fills with quotient bits from the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
            count_reg   <= wsma_pkg::DIV_COUNT_BITS'(wsma_pkg::DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            work_reg  <= work_next;
            rem_reg   <= rem_next;
            count_reg <= count_reg - wsma_pkg::DIV_COUNT_BITS'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[wsma_pkg::SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

### design/windowed_sma_ema_top.sv
`default_nettype none

// Sliding-window simple and exponential moving average. Each sample beat is
// stored in a 64-entry ring (window_length entries in use) and answered by one
// result beat with the truncated mean of the stored samples and an EMA run from
// the oldest stored sample to the newest, rounded at each step. The result beat
// appears once its sample is finished, and the block is ready again in that same
// cycle. The EMA shares one 17x32 multiplier, a new-sample product and then an
// old-average product per stored sample after the oldest, and the mean comes
// from a bit-serial divider that takes 38 steps in parallel with it.
// The block takes no new sample until the current one is finished; a finished
// result waits in the output register without holding up the next sample.
// Writing window_length (index 0) empties the window; smoothing_factor
// (index 1) is clamped to 1.0. The ring needs no clearing after reset.
module windowed_sma_ema_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wsma_cfg_if.sink    cfg,
    wsma_in_if.sink     samples,
    wsma_out_if.source  results
);

    localparam int SB = wsma_pkg::SAMPLE_BITS;
    localparam int AB = wsma_pkg::ADDR_BITS;
    localparam int WB = wsma_pkg::WIN_BITS;
    localparam int FB = wsma_pkg::FACTOR_BITS;
    localparam int PB = wsma_pkg::PROD_BITS;
    localparam int UB = wsma_pkg::SUM_BITS;

    // Control state
    wsma_pkg::state_t state_reg;
    logic [WB-1:0]    window_length_reg;
    logic [FB-1:0]    factor_reg;
    logic [AB-1:0]    write_pos_reg;
    logic [WB-1:0]    fill_reg;
    logic [UB-1:0]    sum_reg;
    logic             out_valid_reg;

    // Datapath registers
    logic [SB-1:0]    sample_reg;
    logic [AB-1:0]    pos_reg;
    logic [AB-1:0]    idx_reg;
    logic [AB-1:0]    steps_reg;
    logic [SB-1:0]    ema_reg;
    logic [PB-1:0]    prod_reg;
    logic [SB-1:0]    simple_out_reg;
    logic [SB-1:0]    ema_out_reg;

    // Combinational signals
    logic [WB-1:0]    win;
    logic             in_accept;
    logic             cfg_accept;
    logic             out_load;
    logic [AB-1:0]    pos_sel;
    logic             filling;
    logic [WB-1:0]    fill_next;
    logic [UB-1:0]    sum_next;
    logic [WB-1:0]    pos_inc;
    logic [AB-1:0]    pos_next;
    logic [AB-1:0]    start_next;
    logic [WB-1:0]    idx_inc;
    logic [AB-1:0]    idx_next;
    logic [FB-1:0]    mul_a;
    logic [SB-1:0]    mul_b;
    logic [PB-1:0]    mul_p;
    logic [PB-1:0]    ema_sum;
    logic [SB-1:0]    ema_next;
    logic [FB-1:0]    factor_in;
    logic [SB-1:0]    rd_data;
    logic             div_done;
    logic [SB-1:0]    quotient;

    assign win        = wsma_pkg::effective_window(window_length_reg);
    assign in_accept  = samples.valid && samples.ready;
    assign cfg_accept = cfg.valid && cfg.ready;
    assign out_load   = (state_reg == wsma_pkg::S_FINISH) && div_done
                        && (!out_valid_reg || results.ready);

    assign cfg.ready     = 1'b1;
    assign samples.ready = (state_reg == wsma_pkg::S_IDLE);

    // Ring bookkeeping for the beat being stored.
    always_comb
    begin
        pos_sel    = ({1'b0, write_pos_reg} >= win) ? '0 : write_pos_reg;
        filling    = (fill_reg < win);
        fill_next  = filling ? fill_reg + WB'(1) : fill_reg;
        sum_next   = sum_reg + UB'(sample_reg) - (filling ? '0 : UB'(rd_data));
        pos_inc    = {1'b0, pos_reg} + WB'(1);
        pos_next   = (pos_inc >= win) ? '0 : pos_inc[AB-1:0];
        start_next = (fill_next < win) ? '0 : pos_next;
        idx_inc    = {1'b0, idx_reg} + WB'(1);
        idx_next   = (idx_inc >= win) ? '0 : idx_inc[AB-1:0];
    end

    // Shared multiplier: a*x in S_MUL_NEW, then (1-a)*ema and the rounded sum in S_MUL_OLD.
    always_comb
    begin
        mul_a    = (state_reg == wsma_pkg::S_MUL_NEW) ? factor_reg
                                                      : wsma_pkg::ONE_Q16 - factor_reg;
        mul_b    = (state_reg == wsma_pkg::S_MUL_NEW) ? rd_data : ema_reg;
        mul_p    = PB'(mul_a) * PB'(mul_b);
        ema_sum  = prod_reg + mul_p + wsma_pkg::ROUND_HALF;
        ema_next = ema_sum[wsma_pkg::FRAC_BITS +: SB];
    end

    // Smoothing factor saturates at 1.0.
    assign factor_in = (cfg.data > wsma_pkg::ONE_Q16) ? wsma_pkg::ONE_Q16 : cfg.data;

    // Sequencer, configuration registers and window state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= wsma_pkg::S_IDLE;
            window_length_reg <= wsma_pkg::WINDOW_LENGTH_RESET;
            factor_reg        <= wsma_pkg::SMOOTHING_RESET;
            write_pos_reg     <= '0;
            fill_reg          <= '0;
            sum_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_accept)
            begin
                if (cfg.index == wsma_pkg::REG_WINDOW_LENGTH)
                begin
                    window_length_reg <= cfg.data[WB-1:0];
                    write_pos_reg     <= '0;
                    fill_reg          <= '0;
                    sum_reg           <= '0;
                end
                else
                begin
                    factor_reg <= factor_in;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                wsma_pkg::S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= wsma_pkg::S_OLD;
                    end
                end
                wsma_pkg::S_OLD:
                begin
                    state_reg <= wsma_pkg::S_UPDATE;
                end
                wsma_pkg::S_UPDATE:
                begin
                    fill_reg      <= fill_next;
                    sum_reg       <= sum_next;
                    write_pos_reg <= pos_next;
                    state_reg     <= wsma_pkg::S_LOAD;
                end
                wsma_pkg::S_LOAD:
                begin
                    state_reg <= wsma_pkg::S_INIT;
                end
                wsma_pkg::S_INIT:
                begin
                    state_reg <= (steps_reg == '0) ? wsma_pkg::S_FINISH : wsma_pkg::S_MUL_NEW;
                end
                wsma_pkg::S_MUL_NEW:
                begin
                    state_reg <= wsma_pkg::S_MUL_OLD;
                end
                wsma_pkg::S_MUL_OLD:
                begin
                    state_reg <= (steps_reg == AB'(1)) ? wsma_pkg::S_FINISH
                                                       : wsma_pkg::S_MUL_NEW;
                end
                wsma_pkg::S_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= wsma_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= wsma_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Datapath. The RAM read address is idx_reg; read data is registered in the RAM and follows it in the next cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            wsma_pkg::S_IDLE:
            begin
                sample_reg <= samples.sample;
                pos_reg    <= pos_sel;
                idx_reg    <= pos_sel;
            end
            wsma_pkg::S_UPDATE:
            begin
                idx_reg   <= start_next;
                steps_reg <= AB'(fill_next - WB'(1));
            end
            wsma_pkg::S_LOAD:
            begin
                idx_reg <= idx_next;
            end
            wsma_pkg::S_INIT:
            begin
                ema_reg <= rd_data;
            end
            wsma_pkg::S_MUL_NEW:
            begin
                prod_reg <= mul_p;
                idx_reg  <= idx_next;
            end
            wsma_pkg::S_MUL_OLD:
            begin
                ema_reg   <= ema_next;
                steps_reg <= steps_reg - AB'(1);
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            simple_out_reg <= quotient;
            ema_out_reg    <= ema_reg;
        end
    end

    // Sample ring: written once per beat, read for the evicted value and the EMA walk.
    wsma_ram #(
        .WIDTH (SB),
        .DEPTH (wsma_pkg::WINDOW_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (state_reg == wsma_pkg::S_UPDATE),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // Mean of the window, started once the new sum is known.
    wsma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == wsma_pkg::S_UPDATE),
        .dividend (sum_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (quotient)
    );

    assign results.valid               = out_valid_reg;
    assign results.simple_average      = simple_out_reg;
    assign results.exponential_average = ema_out_reg;

endmodule

`default_nettype wire

### design/wsma_checker.sv
`default_nettype none

// Port-level checks for the moving-average block.
module wsma_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic [wsma_pkg::SAMPLE_BITS-1:0] in_sample,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [wsma_pkg::SAMPLE_BITS-1:0] out_simple,
    input wire logic [wsma_pkg::SAMPLE_BITS-1:0] out_ema,
    input wire logic                             cfg_valid,
    input wire logic                             cfg_ready,
    input wire wsma_pkg::cfg_index_t             cfg_index
);

    logic                             in_beat;
    logic                             out_beat;
    logic                             clear_beat;
    logic [1:0]                       pending_reg;
    logic                             empty_reg;
    logic                             solo_reg;
    logic [wsma_pkg::SAMPLE_BITS-1:0] solo_sample_reg;

    assign in_beat    = in_valid && in_ready;
    assign out_beat   = out_valid && out_ready;
    assign clear_beat = cfg_valid && cfg_ready && (cfg_index == wsma_pkg::REG_WINDOW_LENGTH);

    // Count of samples taken whose results are not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_beat && !out_beat)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    // Track the first sample after the window was emptied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= 1'b1;
            solo_reg  <= 1'b0;
        end
        else if (clear_beat)
        begin
            empty_reg <= 1'b1;
        end
        else if (in_beat)
        begin
            empty_reg <= 1'b0;
            solo_reg  <= empty_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            solo_sample_reg <= in_sample;
        end
    end

    // The block works on one sample at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("sample taken while the previous one is in work");

    // Every result beat answers a sample, and at most two are ever in flight.
    a_result_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || (pending_reg != 2'd0)) && (pending_reg != 2'd3))
        else $error("result without a matching sample");

    // With one sample stored, both averages equal that sample.
    a_single_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && solo_reg && (pending_reg == 2'd1))
        |-> ((out_simple == solo_sample_reg) && (out_ema == solo_sample_reg)))
        else $error("single-sample window gives a wrong average");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready)
        |=> (out_valid && $stable(out_simple) && $stable(out_ema)))
        else $error("stalled result changed");

endmodule

bind windowed_sma_ema_top wsma_checker u_wsma_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .in_sample  (samples.sample),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_simple (results.simple_average),
    .out_ema    (results.exponential_average),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_index  (cfg.index)
);

`default_nettype wire

### tb/tb_windowed_sma_ema_top.sv
`default_nettype none

module tb_windowed_sma_ema_top;
    import wsma_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 160;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_SAMPLES = 1375;
    localparam int MAX_REPORTS    = 10;
    localparam int DIRECTED_ROWS  = 35;

    localparam logic [WIN_BITS-1:0]    LENGTH_AT_RESET = 7'd20;
    localparam logic [FACTOR_BITS-1:0] WEIGHT_AT_RESET = 17'd6554;
    localparam logic [63:0]            HALF_LSB        = 64'd32768;

    // One result beat: both averages.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] simple_average;
        logic [SAMPLE_BITS-1:0] exponential_average;
    } averages_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    typedef enum int unsigned {
        ALWAYS_READY,
        RANDOM_READY,
        EVERY_THIRD_LOW,
        STALL_RUNS
    } stall_mode_t;

    // A directed row either writes a register or sends a sample; a sample row
    // may carry its expected averages when they are obvious.
    typedef struct {
        row_kind_t   kind;
        cfg_index_t  index;
        logic [31:0] value;
        bit          typed;
        averages_t   expected;
    } stim_row_t;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h0001_0000, 1'b1, '{32'h0001_0000, 32'h0001_0000}},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 32'd1, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'hA5A5_A5A5, 1'b1, '{32'hA5A5_A5A5, 32'hA5A5_A5A5}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h5A5A_5A5A, 1'b1, '{32'h5A5A_5A5A, 32'h5A5A_5A5A}},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 32'd0, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h1234_5678, 1'b1, '{32'h1234_5678, 32'h1234_5678}},
        '{ROW_WRITE, REG_SMOOTHING_FACTOR, 32'd65536, 1'b0, '{32'd0, 32'd0}},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 32'd4, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h0000_0000, 1'b0, '{32'd0, 32'd0}},
        '{ROW_WRITE, REG_SMOOTHING_FACTOR, 32'd0, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h0003_0000, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h0005_0000, 1'b0, '{32'd0, 32'd0}},
        '{ROW_WRITE, REG_SMOOTHING_FACTOR, 32'h0001_FFFF, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h0007_0000, 1'b0, '{32'd0, 32'd0}},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 32'd127, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h8000_0000, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h7FFF_FFFF, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h0000_0001, 1'b0, '{32'd0, 32'd0}},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 32'd65, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'hFFFF_0000, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h0000_FFFF, 1'b0, '{32'd0, 32'd0}},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 32'h0001_FF83, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h1111_1111, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h2222_2222, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h3333_3333, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h4444_4444, 1'b0, '{32'd0, 32'd0}},
        '{ROW_WRITE, REG_SMOOTHING_FACTOR, 32'd6554, 1'b0, '{32'd0, 32'd0}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 32'h0002_0000, 1'b0, '{32'd0, 32'd0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    wsma_cfg_if cfg_bus ();
    wsma_in_if  sample_bus ();
    wsma_out_if result_bus ();

    windowed_sma_ema_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .samples (sample_bus),
        .results (result_bus)
    );

    // Shadow of the window: ring, head, fill count, running sum and registers.
    logic [SAMPLE_BITS-1:0] window_ring [WINDOW_MAX];
    int unsigned            ring_head      = 0;
    int unsigned            ring_fill      = 0;
    logic [SUM_BITS-1:0]    ring_total     = '0;
    logic [WIN_BITS-1:0]    length_setting = LENGTH_AT_RESET;
    logic [FACTOR_BITS-1:0] weight_setting = WEIGHT_AT_RESET;

    averages_t   pending_averages [$];
    bit          row_typed;
    averages_t   row_expected;
    bit          hold_request;
    bit          windows_seen [WINDOW_MAX+1];
    int unsigned failures      = 0;
    int unsigned samples_taken = 0;
    int unsigned results_seen  = 0;
    int unsigned writes_done   = 0;
    int unsigned long_holds    = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // A written length of zero means one; anything past the ring depth means the depth.
    function automatic int unsigned effective_length(input logic [WIN_BITS-1:0] len);
        if (len == '0)
        begin
            return 1;
        end
        if (len > WINDOW_MAX)
        begin
            return WINDOW_MAX;
        end
        return len;
    endfunction

    // Store one sample, then recompute the mean and walk the EMA oldest to newest.
    function automatic averages_t advance_window(input logic [SAMPLE_BITS-1:0] x);
        int unsigned win;
        int unsigned slot;
        int unsigned oldest;
        int unsigned pick;
        int unsigned step;
        logic [63:0] ema;
        averages_t   res;
        win = effective_length(length_setting);
        slot = (ring_head >= win) ? 0 : ring_head;
        if (ring_fill < win)
        begin
            ring_fill++;
            ring_total = ring_total + x;
        end
        else
        begin
            ring_total = ring_total - window_ring[slot] + x;
        end
        window_ring[slot] = x;
        slot = (slot + 1 >= win) ? 0 : slot + 1;
        ring_head = slot;
        oldest = (ring_fill < win) ? 0 : slot;
        ema = 64'(window_ring[oldest]);
        for (step = 1; step < ring_fill; step++)
        begin
            pick = oldest + step;
            if (pick >= win)
            begin
                pick = pick - win;
            end
            ema = (64'(weight_setting) * 64'(window_ring[pick])
                   + (64'(ONE_Q16) - 64'(weight_setting)) * ema + HALF_LSB) >> FRAC_BITS;
        end
        res.simple_average      = SAMPLE_BITS'(ring_total / SUM_BITS'(ring_fill));
        res.exponential_average = ema[SAMPLE_BITS-1:0];
        return res;
    endfunction

    // Register write: the length empties the window, the factor saturates at one.
    function automatic void apply_register(input cfg_index_t idx,
                                           input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_WINDOW_LENGTH:
            begin
                length_setting = data[WIN_BITS-1:0];
                ring_head = 0;
                ring_fill = 0;
                ring_total = '0;
                windows_seen[effective_length(length_setting)] = 1'b1;
            end
            REG_SMOOTHING_FACTOR:
            begin
                weight_setting = (data > ONE_Q16) ? ONE_Q16 : data;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("Mismatch: %s", msg);
        end
    endtask

    task automatic wait_drained();
        while (pending_averages.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Offer one sample beat and return once it has been taken.
    task automatic offer_sample(input logic [SAMPLE_BITS-1:0] x, input bit typed,
                                input averages_t expected);
        @(negedge clk);
        row_typed = typed;
        row_expected = expected;
        sample_bus.valid <= 1'b1;
        sample_bus.sample <= x;
        @(posedge clk);
        while (!sample_bus.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic sender_gap(input int unsigned cycles);
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Registers change only with the block idle and every result collected.
    task automatic write_register(input cfg_index_t idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Watch all three channels at the rising edge: check results first, then
    // apply register writes and predict for newly taken samples.
    initial
    begin : beat_monitor
        averages_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (result_bus.valid && result_bus.ready)
                begin
                    if (pending_averages.size() == 0)
                    begin
                        note_failure($sformatf("result sma=%h ema=%h with nothing expected",
                            result_bus.simple_average, result_bus.exponential_average));
                    end
                    else
                    begin
                        want = pending_averages.pop_front();
                        if (result_bus.simple_average !== want.simple_average)
                        begin
                            note_failure($sformatf("result %0d simple average exp %h got %h",
                                results_seen, want.simple_average,
                                result_bus.simple_average));
                        end
                        if (result_bus.exponential_average !== want.exponential_average)
                        begin
                            note_failure($sformatf("result %0d exponential average exp %h got %h",
                                results_seen, want.exponential_average,
                                result_bus.exponential_average));
                        end
                    end
                    results_seen++;
                end
                if (cfg_bus.valid && cfg_bus.ready)
                begin
                    apply_register(cfg_bus.index, cfg_bus.data);
                    writes_done++;
                end
                if (sample_bus.valid && sample_bus.ready)
                begin
                    want = advance_window(sample_bus.sample);
                    if (row_typed)
                    begin
                        want = row_expected;
                    end
                    pending_averages.insert(pending_averages.size(), want);
                    samples_taken++;
                end
            end
        end
    end

    // Result side back-pressure, with an occasional long hold-off on request.
    initial
    begin : result_receiver
        int unsigned tick;
        int unsigned stall_left;
        stall_mode_t mode;
        tick = 0;
        stall_left = 0;
        mode = ALWAYS_READY;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                long_holds++;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            tick++;
            if (tick % 200 == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
            end
            case (mode)
                ALWAYS_READY:
                begin
                    result_bus.ready <= 1'b1;
                end
                RANDOM_READY:
                begin
                    result_bus.ready <= ($urandom_range(0, 3) != 0);
                end
                EVERY_THIRD_LOW:
                begin
                    result_bus.ready <= (tick % 3 != 0);
                end
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        result_bus.ready <= 1'b0;
                    end
                    else
                    begin
                        result_bus.ready <= 1'b1;
                        if ($urandom_range(0, 15) == 0)
                        begin
                            stall_left = $urandom_range(1, 20);
                        end
                    end
                end
            endcase
        end
    end

    // Give up when no beat has moved on any channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sample_bus.valid && sample_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
                || (result_bus.valid && result_bus.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_averages.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        logic [SAMPLE_BITS-1:0]   x;
        logic [WIN_BITS-1:0]      length_pick;
        logic [9:0]               junk_bits;
        logic [CFG_DATA_BITS-1:0] weight_pick;
        int unsigned              row;
        int unsigned              phase_no;
        int unsigned              phase_items;
        int unsigned              item;
        int unsigned              random_sent;
        int unsigned              burst_left;
        int unsigned              pick;
        int unsigned              distinct_windows;
        bit                       gapless;

        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_WINDOW_LENGTH;
        cfg_bus.data = '0;
        sample_bus.valid = 1'b0;
        sample_bus.sample = '0;
        hold_request = 1'b0;
        row_typed = 1'b0;
        row_expected = '0;
        x = '0;
        random_sent = 0;
        phase_no = 0;
        windows_seen[effective_length(LENGTH_AT_RESET)] = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: extremes, clamped settings and single-sample windows.
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (directed_rows[row].kind == ROW_WRITE)
            begin
                write_register(directed_rows[row].index,
                               directed_rows[row].value[CFG_DATA_BITS-1:0]);
            end
            else
            begin
                offer_sample(directed_rows[row].value, directed_rows[row].typed,
                             directed_rows[row].expected);
            end
        end

        // Random phases: new settings, then a stream of samples in bursts.
        while (random_sent < RANDOM_SAMPLES)
        begin
            phase_no++;
            junk_bits = '0;
            pick = $urandom_range(0, 9);
            if (phase_no == 1)
            begin
                length_pick = 7'd1;
            end
            else if (phase_no == 2 || pick == 7)
            begin
                length_pick = 7'd64;
            end
            else if (pick <= 5)
            begin
                length_pick = 7'($urandom_range(1, 12));
            end
            else if (pick == 6)
            begin
                length_pick = 7'($urandom_range(13, 63));
            end
            else if (pick == 8)
            begin
                length_pick = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
            end
            else
            begin
                length_pick = 7'($urandom_range(2, 8));
                junk_bits = 10'($urandom);
            end

            pick = $urandom_range(0, 5);
            if (phase_no == 1 || pick == 0)
            begin
                weight_pick = '0;
            end
            else if (phase_no == 2 || pick == 1)
            begin
                weight_pick = ONE_Q16;
            end
            else if (pick == 2)
            begin
                weight_pick = 17'($urandom_range(65537, 131071));
            end
            else
            begin
                weight_pick = 17'($urandom_range(0, 65535));
            end

            write_register(REG_WINDOW_LENGTH, {junk_bits, length_pick});
            if (phase_no <= 2 || $urandom_range(0, 3) != 0)
            begin
                write_register(REG_SMOOTHING_FACTOR, weight_pick);
            end

            phase_items = (effective_length(length_pick) > 16) ? $urandom_range(20, 50)
                                                                : $urandom_range(60, 120);
            gapless = (phase_no == 2 || phase_no == 6 || $urandom_range(0, 3) == 0);
            if (phase_no == 2 || phase_no == 6)
            begin
                hold_request = 1'b1;
            end
            burst_left = 0;

            for (item = 0; item < phase_items; item++)
            begin
                if (!gapless)
                begin
                    if (burst_left == 0)
                    begin
                        sender_gap($urandom_range(1, 8));
                        burst_left = $urandom_range(1, 24);
                    end
                    burst_left--;
                end
                if ($urandom_range(0, 79) == 0)
                begin
                    sender_gap(1);
                    wait_drained();
                end
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    x = '0;
                end
                else if (pick == 1)
                begin
                    x = '1;
                end
                else if (pick == 2)
                begin
                    x = 32'($urandom_range(0, 32'hFFFF));
                end
                else if (pick == 3)
                begin
                    x = {16'hFFFF, 16'($urandom)};
                end
                else if (pick != 4)
                begin
                    x = $urandom;
                end
                offer_sample(x, 1'b0, '0);
                random_sent++;
            end
        end

        sender_gap(1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        distinct_windows = 0;
        for (row = 1; row <= WINDOW_MAX; row++)
        begin
            distinct_windows += windows_seen[row];
        end
        $display("Run covered %0d samples and %0d results over %0d random phases.",
                 samples_taken, results_seen, phase_no);
        $display("%0d register writes, %0d window lengths in use, %0d long output hold-offs.",
                 writes_done, distinct_windows, long_holds);
        if (failures == 0 && pending_averages.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
